// ===== sv/mqc_pkg.sv =====
// ---------------------------------------------------------------------------
// mqc_pkg: shared types and constants
// Payload structs, register map and grading codes of the quality classifier.
// ---------------------------------------------------------------------------
package mqc_pkg;

	localparam int DefaultDepth      = 16;
	localparam int DefaultSampleBits = 16;
	localparam int FieldBits         = 16;
	localparam int SpreadBits        = 41;

	// Register byte addresses.
	localparam logic [3:0] AddrVarianceLimit    = 4'h0;
	localparam logic [3:0] AddrMagnitudeFloor   = 4'h4;
	localparam logic [3:0] AddrMagnitudeCeiling = 4'h8;

	localparam logic [23:0] ResetVarianceLimit    = 24'd500;
	localparam logic [15:0] ResetMagnitudeFloor   = 16'd100;
	localparam logic [15:0] ResetMagnitudeCeiling = 16'd1000;

	// Quality codes.
	localparam logic [1:0] QualityExcellent = 2'd0;
	localparam logic [1:0] QualityGood      = 2'd1;
	localparam logic [1:0] QualityPoor      = 2'd2;
	localparam logic [1:0] QualityInvalid   = 2'd3;

	typedef struct packed {
		logic signed [FieldBits-1:0] kayak_field_x;
		logic signed [FieldBits-1:0] kayak_field_y;
		logic signed [FieldBits-1:0] kayak_field_z;
		logic signed [FieldBits-1:0] paddle_field_x;
		logic signed [FieldBits-1:0] paddle_field_y;
		logic signed [FieldBits-1:0] paddle_field_z;
	} sample_pair_t;

	typedef struct packed {
		logic [1:0]            quality;
		logic                  anomaly;
		logic [SpreadBits-1:0] scaled_spread;
	} grade_t;

	// Configuration seen by the back end.
	typedef struct packed {
		logic [23:0] variance_limit;
		logic [15:0] magnitude_floor;
		logic [15:0] magnitude_ceiling;
	} mqc_cfg_t;

endpackage

// ===== sv/mqc_window.sv =====
// ---------------------------------------------------------------------------
// mqc_window: one sensor's sliding window
// Replaces the oldest entry and updates running sums; one request per cycle
// in; sums, squares and magnitude registered, then spread and failure out.
// ---------------------------------------------------------------------------
module mqc_window import mqc_pkg::*; #(
	parameter int DEPTH       = DefaultDepth,
	parameter int SAMPLE_BITS = DefaultSampleBits
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic [$clog2(DEPTH)-1:0]        slot,
	input  logic signed [3*FieldBits-1:0]   sample,
	input  logic [15:0]                     magnitude_floor,
	input  logic [15:0]                     magnitude_ceiling,
	output logic [SpreadBits+2:0]           spread_s2,
	output logic                            failed_s2
);

	localparam int SumBits = SAMPLE_BITS + $clog2(DEPTH) + 1;
	localparam int SqBits  = 2 * SAMPLE_BITS + $clog2(DEPTH);
	localparam int AxBits  = SqBits + $clog2(DEPTH) + 1;
	localparam int ProdBits = 2 * SAMPLE_BITS;

	logic [DEPTH-1:0]                    valid_q;
	logic signed [SAMPLE_BITS-1:0]       win_q [DEPTH][3];
	logic signed [SumBits-1:0]           sum_q [3];
	logic [SqBits-1:0]                   sqsum_q [3];
	logic signed [SAMPLE_BITS-1:0]       cur [3];
	logic signed [SAMPLE_BITS-1:0]       old [3];
	logic signed [SumBits-1:0]           sum_next [3];
	logic [SqBits-1:0]                   sqsum_next [3];
	logic [SqBits-1:0]                   cur_sq [3];
	logic [SqBits-1:0]                   sqsum_s1 [3];
	logic [2*SAMPLE_BITS+1:0]            mag_s1;
	logic                                zero_s1;
	logic [AxBits-1:0]                   axis_var [3];

	// Unpack and fetch the entry being replaced; never-written entries read zero.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cur[a] = sample[(2-a)*FieldBits +: SAMPLE_BITS];
			old[a] = valid_q[slot] ? win_q[slot][a] : '0;
			cur_sq[a] = SqBits'($unsigned(ProdBits'(cur[a]) * ProdBits'(cur[a])));
			sum_next[a] = sum_q[a] - SumBits'(old[a]) + SumBits'(cur[a]);
			sqsum_next[a] = sqsum_q[a]
			              - SqBits'($unsigned(ProdBits'(old[a]) * ProdBits'(old[a])))
			              + cur_sq[a];
		end
	end

	// Window state and first output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int a = 0; a < 3; a++) begin
				sum_q[a]   <= '0;
				sqsum_q[a] <= '0;
			end
		end else if (advance) begin
			valid_q[slot] <= 1'b1;
			for (int a = 0; a < 3; a++) begin
				sum_q[a]   <= sum_next[a];
				sqsum_q[a] <= sqsum_next[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int a = 0; a < 3; a++) begin
				win_q[slot][a] <= cur[a];
				sqsum_s1[a]    <= sqsum_next[a];
			end
			zero_s1 <= (cur[0] == 0) && (cur[1] == 0) && (cur[2] == 0);
			mag_s1  <= (2*SAMPLE_BITS+2)'(cur_sq[0]) + (2*SAMPLE_BITS+2)'(cur_sq[1])
			         + (2*SAMPLE_BITS+2)'(cur_sq[2]);
		end
	end

	logic signed [SumBits-1:0] sum_s1 [3];
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int a = 0; a < 3; a++) sum_s1[a] <= sum_next[a];
		end
	end

	// Second stage: variance per axis and magnitude compare.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			axis_var[a] = AxBits'(DEPTH) * AxBits'(sqsum_s1[a])
			            - AxBits'($unsigned((2*SumBits)'(sum_s1[a])
			                                * (2*SumBits)'(sum_s1[a])));
		end
	end

	// The second stage loads every cycle so a request never waits for the next.
	always_ff @(posedge clk) begin
		spread_s2 <= (SpreadBits+3)'(axis_var[0] + axis_var[1] + axis_var[2]);
		failed_s2 <= zero_s1
		          || (mag_s1 < (2*SAMPLE_BITS+2)'(32'(magnitude_floor) * 32'(magnitude_floor)))
		          || (mag_s1 > (2*SAMPLE_BITS+2)'(32'(magnitude_ceiling)
		                                         * 32'(magnitude_ceiling)));
	end

endmodule

// ===== sv/mqc_grade.sv =====
// ---------------------------------------------------------------------------
// mqc_grade: back end
// Compares the larger spread against scaled thresholds and forms the result.
// ---------------------------------------------------------------------------
module mqc_grade import mqc_pkg::*; #(
	parameter int DEPTH = DefaultDepth
) (
	input  logic [SpreadBits+2:0]  kayak_spread,
	input  logic [SpreadBits+2:0]  paddle_spread,
	input  logic                   failed,
	input  mqc_cfg_t               cfg,
	output grade_t                 grade
);

	localparam int LimBits = 24 + 2 * $clog2(DEPTH) + 4;
	localparam int CmpBits = SpreadBits + 3 + 4;

	logic [SpreadBits+2:0] big;
	logic [LimBits-1:0]    limit;
	logic [CmpBits-1:0]    big10;

	always_comb begin
		big   = (kayak_spread > paddle_spread) ? kayak_spread : paddle_spread;
		limit = LimBits'(cfg.variance_limit) * LimBits'(DEPTH * (DEPTH - 1));
		big10 = CmpBits'(big) * CmpBits'(10);
		grade.scaled_spread = big[SpreadBits-1:0];
		grade.anomaly = failed;
		if (failed || CmpBits'(big) >= CmpBits'(limit)) grade.quality = QualityInvalid;
		else if (big10 < CmpBits'(limit) * CmpBits'(3)) grade.quality = QualityExcellent;
		else if (big10 < CmpBits'(limit) * CmpBits'(7)) grade.quality = QualityGood;
		else grade.quality = QualityPoor;
	end

endmodule

// ===== sv/magnetometer_quality_classifier_top.sv =====
// ---------------------------------------------------------------------------
// magnetometer_quality_classifier_top
// Grades pairs of magnetometer samples by sliding-window variance.
// ---------------------------------------------------------------------------
// Usage: push a sample pair while full is low; each request yields one
// result, read with pop while empty is low, oldest first.
// The front end updates both windows and computes spreads in a two-stage
// pipeline that never stalls, since intake reserves a queue slot; the back end
// grades the stage output and writes it into a four-entry result queue.
// Throughput is one pair per cycle while full is low; empty falls once the
// result of an accepted push leaves both stages and enters the queue.
// full rises only when the result queue, counting requests
// in flight, holds four entries, so a stalled receiver stops intake there.
// Reset clears windows, sums, queue and registers to their defaults. The user
// writes registers over APB only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module magnetometer_quality_classifier_top import mqc_pkg::*; #(
	parameter int DEPTH       = DefaultDepth,
	parameter int SAMPLE_BITS = DefaultSampleBits
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  sample_pair_t in_item,
	output logic         empty,
	input  logic         pop,
	output grade_t       out_item,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int QDepth = 4;

	mqc_cfg_t                   cfg_q;
	logic [$clog2(DEPTH)-1:0]   slot_q;
	logic                       v_s1, v_s2;
	logic [2:0]                 count_q;
	logic [1:0]                 wr_q, rd_q;
	grade_t                     queue_q [QDepth];
	logic [SpreadBits+2:0]      k_spread, p_spread;
	logic                       k_fail, p_fail;
	grade_t                     grade;
	logic                       accept, take;
	logic [2:0]                 inflight;

	// Configuration registers.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.variance_limit    <= ResetVarianceLimit;
			cfg_q.magnitude_floor   <= ResetMagnitudeFloor;
			cfg_q.magnitude_ceiling <= ResetMagnitudeCeiling;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				AddrVarianceLimit:    cfg_q.variance_limit    <= pwdata[23:0];
				AddrMagnitudeFloor:   cfg_q.magnitude_floor   <= pwdata[15:0];
				AddrMagnitudeCeiling: cfg_q.magnitude_ceiling <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			AddrVarianceLimit:    prdata = {8'd0, cfg_q.variance_limit};
			AddrMagnitudeFloor:   prdata = {16'd0, cfg_q.magnitude_floor};
			AddrMagnitudeCeiling: prdata = {16'd0, cfg_q.magnitude_ceiling};
			default:              prdata = '0;
		endcase
	end

	// Intake control: reserve a queue slot for every request in flight.
	assign inflight = count_q + 3'(v_s1) + 3'(v_s2);
	assign full     = (inflight >= 3'(QDepth));
	assign accept   = push && !full;
	assign take     = pop && !empty;
	assign empty    = (count_q == 3'd0);

	// The windows advance on each accepted push; bubbles carry valid low.
	mqc_window #(.DEPTH(DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_kayak (
		.clk, .arst_n, .advance(accept), .slot(slot_q),
		.sample({in_item.kayak_field_x, in_item.kayak_field_y, in_item.kayak_field_z}),
		.magnitude_floor(cfg_q.magnitude_floor),
		.magnitude_ceiling(cfg_q.magnitude_ceiling),
		.spread_s2(k_spread), .failed_s2(k_fail)
	);
	mqc_window #(.DEPTH(DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_paddle (
		.clk, .arst_n, .advance(accept), .slot(slot_q),
		.sample({in_item.paddle_field_x, in_item.paddle_field_y, in_item.paddle_field_z}),
		.magnitude_floor(cfg_q.magnitude_floor),
		.magnitude_ceiling(cfg_q.magnitude_ceiling),
		.spread_s2(p_spread), .failed_s2(p_fail)
	);

	mqc_grade #(.DEPTH(DEPTH)) u_grade (
		.kayak_spread(k_spread), .paddle_spread(p_spread),
		.failed(k_fail || p_fail), .cfg(cfg_q), .grade
	);

	// Stage valids, write slot and result queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			count_q <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (accept) slot_q <= (slot_q == $clog2(DEPTH)'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
			if (v_s2) wr_q <= wr_q + 1'b1;
			if (take) rd_q <= rd_q + 1'b1;
			count_q <= count_q + 3'(v_s2) - 3'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) queue_q[wr_q] <= grade;
	end

	assign out_item = queue_q[rd_q];

endmodule

// ===== sv/mqc_checker.sv =====
// ---------------------------------------------------------------------------
// mqc_checker: port-level checks
// Watches the queue handshakes of the classifier top level.
// ---------------------------------------------------------------------------
module mqc_checker import mqc_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   push,
	input logic   full,
	input logic   empty,
	input logic   pop,
	input grade_t out_item
);

	// A waiting result that is not taken stays the same.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable(out_item))
		else $error("result changed while waiting");

	// An invalid grade is the only one with the anomaly flag.
	a_anom: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.anomaly) |-> (out_item.quality == QualityInvalid))
		else $error("anomaly without invalid grade");

	// No result appears without an earlier request.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		($past(empty) && !empty) |-> $past(push && !full, 3))
		else $error("result without request");

endmodule

bind magnetometer_quality_classifier_top mqc_checker u_mqc_checker (
	.clk, .arst_n, .push, .full, .empty, .pop, .out_item
);

// ===== test/tb_magnetometer_quality_classifier_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_magnetometer_quality_classifier_top
// Sends sample pairs through the classifier under random push and pop
// gaps. A scoreboard mirrors the sliding windows and grading, and
// compares every popped grade with its prediction.
// ---------------------------------------------------------------------------
module tb_magnetometer_quality_classifier_top;
	import mqc_pkg::*;

	localparam int Depth      = DefaultDepth;
	localparam int CycleLimit = 2000000;

	// Mirrors the windows and grades each accepted pair.
	class grade_scoreboard;
		logic signed [15:0] kayak_win[Depth][3];
		logic signed [15:0] paddle_win[Depth][3];
		int                 slot;
		longint             kayak_sum[3], paddle_sum[3];
		longint             kayak_sq[3], paddle_sq[3];
		longint             variance_limit, magnitude_floor, magnitude_ceiling;
		grade_t             pending_grades[$];
		int                 error_count;

		function void clear();
			for (int i = 0; i < Depth; i++) begin
				for (int a = 0; a < 3; a++) begin
					kayak_win[i][a] = 0;
					paddle_win[i][a] = 0;
				end
			end
			for (int a = 0; a < 3; a++) begin
				kayak_sum[a] = 0;
				paddle_sum[a] = 0;
				kayak_sq[a] = 0;
				paddle_sq[a] = 0;
			end
			slot = 0;
			variance_limit = ResetVarianceLimit;
			magnitude_floor = ResetMagnitudeFloor;
			magnitude_ceiling = ResetMagnitudeCeiling;
			error_count = 0;
		endfunction

		function bit magnitude_bad(longint s[3]);
			longint m2;
			if (s[0] == 0 && s[1] == 0 && s[2] == 0) return 1;
			m2 = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
			return m2 < magnitude_floor * magnitude_floor ||
				m2 > magnitude_ceiling * magnitude_ceiling;
		endfunction

		function void note_request(sample_pair_t req);
			longint k[3], p[3];
			longint old, ks, ps, big, lim;
			grade_t g;
			k[0] = req.kayak_field_x;
			k[1] = req.kayak_field_y;
			k[2] = req.kayak_field_z;
			p[0] = req.paddle_field_x;
			p[1] = req.paddle_field_y;
			p[2] = req.paddle_field_z;
			ks = 0;
			ps = 0;
			for (int a = 0; a < 3; a++) begin
				old = kayak_win[slot][a];
				kayak_sum[a] += k[a] - old;
				kayak_sq[a] += k[a] * k[a] - old * old;
				kayak_win[slot][a] = k[a];
				old = paddle_win[slot][a];
				paddle_sum[a] += p[a] - old;
				paddle_sq[a] += p[a] * p[a] - old * old;
				paddle_win[slot][a] = p[a];
				ks += Depth * kayak_sq[a] - kayak_sum[a] * kayak_sum[a];
				ps += Depth * paddle_sq[a] - paddle_sum[a] * paddle_sum[a];
			end
			slot = (slot + 1) % Depth;
			g.anomaly = magnitude_bad(k) || magnitude_bad(p);
			big = ks > ps ? ks : ps;
			lim = variance_limit * Depth * (Depth - 1);
			if (g.anomaly || big >= lim) g.quality = QualityInvalid;
			else if (big * 10 < lim * 3) g.quality = QualityExcellent;
			else if (big * 10 < lim * 7) g.quality = QualityGood;
			else g.quality = QualityPoor;
			g.scaled_spread = big[SpreadBits-1:0];
			pending_grades.push_back(g);
		endfunction

		function void check_grade(grade_t got);
			grade_t want;
			if (pending_grades.size() == 0) begin
				$error("grade popped with none expected");
				error_count++;
				return;
			end
			want = pending_grades.pop_front();
			if (got.quality !== want.quality) begin
				$error("quality: expected %0d, actual %0d", want.quality, got.quality);
				error_count++;
			end
			if (got.anomaly !== want.anomaly) begin
				$error("anomaly: expected %0d, actual %0d", want.anomaly, got.anomaly);
				error_count++;
			end
			if (got.scaled_spread !== want.scaled_spread) begin
				$error("scaled_spread: expected %0d, actual %0d",
					want.scaled_spread, got.scaled_spread);
				error_count++;
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         push = 0;
	logic         full;
	sample_pair_t in_item = '0;
	logic         empty;
	logic         pop = 0;
	grade_t       out_item;
	logic         psel = 0;
	logic         penable = 0;
	logic         pwrite = 0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	grade_scoreboard board = new();
	int              cycle_count = 0;
	bit              pop_stall_long = 0;

	magnetometer_quality_classifier_top dut (.*);

	always #5 clk = ~clk;

	// Abort on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: check accepted grades and choose the next pop at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) board.check_grade(out_item);
			if (pop_stall_long) pop <= ($urandom_range(0, 19) == 0);
			else pop <= ($urandom_range(0, 3) != 0);
		end
	end

	function automatic int gap_length();
		if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
		return $urandom_range(0, 2);
	endfunction

	task automatic write_register(logic [3:0] addr, logic [31:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (addr)
			AddrVarianceLimit:    board.variance_limit = value[23:0];
			AddrMagnitudeFloor:   board.magnitude_floor = value[15:0];
			AddrMagnitudeCeiling: board.magnitude_ceiling = value[15:0];
			default: ;
		endcase
	endtask

	// Present one request and hold it until accepted; push stays high for
	// back-to-back requests and drops only over a gap.
	task automatic send_pair(sample_pair_t req, bit with_gaps);
		int gap;
		gap = with_gaps ? gap_length() : 0;
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		in_item <= req;
		do @(posedge clk); while (full);
		board.note_request(req);
	endtask

	task automatic drain();
		push <= 0;
		while (board.pending_grades.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// One axis value by mode: random, up to 600 with random sign, extreme, near zero.
	function automatic logic signed [15:0] axis_value(int mode);
		logic signed [15:0] mag;
		mag = $signed(16'($urandom_range(0, 600)));
		case (mode)
			0: return 16'($urandom());
			1: return $urandom_range(0, 1) ? mag : -mag;
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return 16'($urandom_range(0, 3)) - 16'sd1;
		endcase
	endfunction

	function automatic sample_pair_t random_pair(int mode);
		sample_pair_t r;
		logic signed [15:0] base[3];
		for (int a = 0; a < 3; a++) base[a] = axis_value(mode);
		r.kayak_field_x = base[0];
		r.kayak_field_y = base[1];
		r.kayak_field_z = base[2];
		// The paddle sample usually tracks the kayak closely.
		if ($urandom_range(0, 3) == 0) begin
			r.paddle_field_x = axis_value(mode);
			r.paddle_field_y = axis_value(mode);
			r.paddle_field_z = axis_value(mode);
		end else begin
			r.paddle_field_x = base[0] + 16'($urandom_range(0, 4)) - 16'sd2;
			r.paddle_field_y = base[1] + 16'($urandom_range(0, 4)) - 16'sd2;
			r.paddle_field_z = base[2] + 16'($urandom_range(0, 4)) - 16'sd2;
		end
		return r;
	endfunction

	initial begin
		sample_pair_t r;
		int           mode;
		board.clear();
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// Directed requests at default limits: zeros, extremes, steady field.
		send_pair('0, 0);
		send_pair({6{16'sh7fff}}, 0);
		send_pair({6{16'sh8000}}, 0);
		send_pair({16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff, 16'sh0000, 16'sh5555}, 0);
		for (int i = 0; i < Depth + 2; i++)
			send_pair({16'sd300, 16'sd200, 16'sd100, 16'sd300, 16'sd201, 16'sd100}, 0);
		drain();

		// Phases through limit settings, extremes included.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					write_register(AddrVarianceLimit, 32'd0);
					write_register(AddrMagnitudeFloor, 32'd0);
					write_register(AddrMagnitudeCeiling, 32'hffff);
				end
				1: begin
					write_register(AddrVarianceLimit, 32'hffffff);
					write_register(AddrMagnitudeFloor, 32'hffff);
					write_register(AddrMagnitudeCeiling, 32'd0);
				end
				2: begin
					write_register(AddrVarianceLimit, 32'hffffff);
					write_register(AddrMagnitudeFloor, 32'd1);
					write_register(AddrMagnitudeCeiling, 32'hffff);
				end
				default: begin
					write_register(AddrVarianceLimit, $urandom_range(50, 200000));
					write_register(AddrMagnitudeFloor, $urandom_range(0, 300));
					write_register(AddrMagnitudeCeiling, $urandom_range(300, 60000));
				end
			endcase
			pop_stall_long = (phase == 4);
			for (int i = 0; i < 150; i++) begin
				mode = $urandom_range(0, 9);
				r = random_pair(mode < 6 ? 1 : mode < 8 ? 0 : mode == 8 ? 2 : 3);
				send_pair(r, phase != 3);
				if (i == 75) drain();
			end
			pop_stall_long = 0;
			drain();
		end

		if (board.error_count == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== magnetometer_quality_classifier_top.f =====
sv/mqc_pkg.sv
sv/mqc_window.sv
sv/mqc_grade.sv
sv/magnetometer_quality_classifier_top.sv
sv/mqc_checker.sv
test/tb_magnetometer_quality_classifier_top.sv
